// ===== hdl/stkundo_pkg.sv =====
package stkundo_pkg;

  // Store geometry.
  localparam int MAIN_DEPTH    = 8;
  localparam int HISTORY_DEPTH = 128;
  localparam int DATA_WIDTH    = 32;

  localparam int MAIN_AW    = (MAIN_DEPTH > 1) ? $clog2(MAIN_DEPTH) : 1;
  localparam int HIST_AW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int MAIN_CNT_W = $clog2(MAIN_DEPTH + 1);
  localparam int HIST_CNT_W = $clog2(HISTORY_DEPTH + 1);

  // Fixed field widths of the ports.
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 3;
  localparam int DEPTH_W    = 4;
  localparam int MCAP_W     = 4;
  localparam int HCAP_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [MAIN_CNT_W-1:0] main_cnt_t;
  typedef logic [HIST_CNT_W-1:0] hist_cnt_t;
  typedef logic [MAIN_AW-1:0]    main_addr_t;
  typedef logic [HIST_AW-1:0]    hist_addr_t;
  typedef logic [STATUS_W-1:0]   status_t;
  typedef logic [OP_W-1:0]       op_t;

  // Operation codes.
  localparam op_t OP_PUSH = 2'd0;
  localparam op_t OP_POP  = 2'd1;
  localparam op_t OP_UNDO = 2'd2;
  localparam op_t OP_SHOW = 2'd3;

  // Result status codes.
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_OVERFLOW  = 3'd1;
  localparam status_t ST_EMPTY     = 3'd2;
  localparam status_t ST_NO_UNDO   = 3'd3;
  localparam status_t ST_HIST_FULL = 3'd4;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_MAIN_CAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIST_CAP = 2'd1;
  localparam logic [MCAP_W-1:0]    MAIN_CAP_RESET = 4'd5;
  localparam logic [HCAP_W-1:0]    HIST_CAP_RESET = 8'd100;

endpackage

// ===== hdl/stack_with_pop_undo.sv =====
// Push and any refused operation: result in the output register in the cycle after input transfer.
// Pop and undo: memory read, then write-back of the moved word and result once the output is free.
// Display: one result per stacked entry; after a first read, each result starts the next read.
// A push or refused item every cycle unless the output stalls; pop, undo and display stall the input.
// Reset (rst_n low, synchronous) empties both stacks and restores the capacities to 5 and 100;
// the store contents are not cleared and are only ever read after being written.
module stack_with_pop_undo (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic signed [31:0] in_value,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_data,
  output logic [2:0]  out_status,
  output logic [3:0]  out_depth_now,
  output logic        out_last,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  // Sequencer states. IDLE takes a new item; the others finish an item whose
  // memory read was already issued.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_UNDO = 2'd2;
  localparam logic [1:0] S_SHOW = 2'd3;

  logic [1:0] state_r, state_nxt;

  stkundo_pkg::main_cnt_t main_count_r, main_count_nxt;
  stkundo_pkg::hist_cnt_t hist_count_r, hist_count_nxt;
  stkundo_pkg::main_cnt_t show_idx_r, show_idx_nxt;

  logic [stkundo_pkg::MCAP_W-1:0] main_cap_r;
  logic [stkundo_pkg::HCAP_W-1:0] hist_cap_r;

  // Output register.
  logic                     out_valid_r, out_valid_nxt;
  stkundo_pkg::data_t       out_data_r, out_data_nxt;
  stkundo_pkg::status_t     out_status_r, out_status_nxt;
  stkundo_pkg::main_cnt_t   out_depth_r, out_depth_nxt;
  logic                     out_last_r, out_last_nxt;

  // Main store: one write port and one registered read port.
  stkundo_pkg::data_t     main_mem [stkundo_pkg::MAIN_DEPTH];
  logic                   main_we, main_re;
  stkundo_pkg::main_addr_t main_waddr, main_raddr;
  stkundo_pkg::data_t     main_wdata;
  stkundo_pkg::data_t     main_rd_r;

  // History store: same organization.
  stkundo_pkg::data_t     hist_mem [stkundo_pkg::HISTORY_DEPTH];
  logic                   hist_we, hist_re;
  stkundo_pkg::hist_addr_t hist_waddr, hist_raddr;
  stkundo_pkg::data_t     hist_wdata;
  stkundo_pkg::data_t     hist_rd_r;

  stkundo_pkg::main_cnt_t main_cap_eff;
  stkundo_pkg::hist_cnt_t hist_cap_eff;
  stkundo_pkg::main_cnt_t main_dec;
  stkundo_pkg::hist_cnt_t hist_dec;
  stkundo_pkg::main_cnt_t main_inc;
  logic                   main_full, hist_full;
  logic                   out_free, in_xfer;

  // Effective capacities: zero acts as one, anything above the store depth
  // acts as the depth.
  always_comb begin
    if (main_cap_r == '0) begin
      main_cap_eff = stkundo_pkg::MAIN_CNT_W'(1);
    end else if (int'(main_cap_r) > stkundo_pkg::MAIN_DEPTH) begin
      main_cap_eff = stkundo_pkg::MAIN_CNT_W'(stkundo_pkg::MAIN_DEPTH);
    end else begin
      main_cap_eff = stkundo_pkg::MAIN_CNT_W'(main_cap_r);
    end
    if (hist_cap_r == '0) begin
      hist_cap_eff = stkundo_pkg::HIST_CNT_W'(1);
    end else if (int'(hist_cap_r) > stkundo_pkg::HISTORY_DEPTH) begin
      hist_cap_eff = stkundo_pkg::HIST_CNT_W'(stkundo_pkg::HISTORY_DEPTH);
    end else begin
      hist_cap_eff = stkundo_pkg::HIST_CNT_W'(hist_cap_r);
    end
  end

  // A lowered capacity can leave the count above it; the compare covers that.
  assign main_full = (main_count_r >= main_cap_eff);
  assign hist_full = (hist_count_r >= hist_cap_eff);
  assign main_dec  = main_count_r - 1'b1;
  assign hist_dec  = hist_count_r - 1'b1;
  assign main_inc  = main_count_r + 1'b1;

  // The output register can take a new result when it is empty or its
  // current result transfers in this cycle.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_xfer  = in_valid && !in_stall;

  // The user must issue configuration writes only while the block is idle; the block itself does not enforce this.
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt      = state_r;
    main_count_nxt = main_count_r;
    hist_count_nxt = hist_count_r;
    show_idx_nxt   = show_idx_r;

    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_depth_nxt  = out_depth_r;
    out_last_nxt   = out_last_r;

    main_we    = 1'b0;
    main_re    = 1'b0;
    main_waddr = main_count_r[stkundo_pkg::MAIN_AW-1:0];
    main_raddr = main_dec[stkundo_pkg::MAIN_AW-1:0];
    main_wdata = in_value;
    hist_we    = 1'b0;
    hist_re    = 1'b0;
    hist_waddr = hist_count_r[stkundo_pkg::HIST_AW-1:0];
    hist_raddr = hist_dec[stkundo_pkg::HIST_AW-1:0];
    hist_wdata = main_rd_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          out_data_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_depth_nxt = main_count_r;
          case (in_operation)
            stkundo_pkg::OP_PUSH: begin
              out_valid_nxt = 1'b1;
              if (main_full) begin
                out_status_nxt = stkundo_pkg::ST_OVERFLOW;
              end else begin
                main_we        = 1'b1;
                main_count_nxt = main_inc;
                out_depth_nxt  = main_inc;
                out_status_nxt = stkundo_pkg::ST_OK;
              end
            end
            stkundo_pkg::OP_POP: begin
              if (main_count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = stkundo_pkg::ST_EMPTY;
              end else begin
                main_re        = 1'b1;
                main_count_nxt = main_dec;
                state_nxt      = S_POP;
              end
            end
            stkundo_pkg::OP_UNDO: begin
              if (hist_count_r == '0 || main_full) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = stkundo_pkg::ST_NO_UNDO;
              end else begin
                hist_re        = 1'b1;
                hist_count_nxt = hist_dec;
                state_nxt      = S_UNDO;
              end
            end
            default: begin
              if (main_count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = stkundo_pkg::ST_EMPTY;
              end else begin
                main_re      = 1'b1;
                show_idx_nxt = main_dec;
                state_nxt    = S_SHOW;
              end
            end
          endcase
        end
      end

      S_POP: begin
        // The popped word is in main_rd_r; record it unless the history is full.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = main_rd_r;
          out_depth_nxt = main_count_r;
          out_last_nxt  = 1'b1;
          if (hist_full) begin
            out_status_nxt = stkundo_pkg::ST_HIST_FULL;
          end else begin
            hist_we        = 1'b1;
            hist_count_nxt = hist_count_r + 1'b1;
            out_status_nxt = stkundo_pkg::ST_OK;
          end
          state_nxt = S_IDLE;
        end
      end

      S_UNDO: begin
        // The restored word is in hist_rd_r; push it back onto the main stack.
        if (out_free) begin
          main_we        = 1'b1;
          main_wdata     = hist_rd_r;
          main_count_nxt = main_inc;
          out_valid_nxt  = 1'b1;
          out_data_nxt   = hist_rd_r;
          out_status_nxt = stkundo_pkg::ST_OK;
          out_depth_nxt  = main_inc;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_SHOW: begin
        // Each cycle with room at the output emits the entry just read and
        // starts the read of the one below it, if any. The read register holds while
        // the output is stalled because no new read is issued.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = main_rd_r;
          out_status_nxt = stkundo_pkg::ST_OK;
          out_depth_nxt  = main_count_r;
          out_last_nxt   = (show_idx_r == '0);
          if (show_idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            main_re      = 1'b1;
            main_raddr   = stkundo_pkg::MAIN_AW'(show_idx_r - 1'b1);
            show_idx_nxt = show_idx_r - 1'b1;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      main_count_r <= '0;
      hist_count_r <= '0;
      show_idx_r   <= '0;
      out_valid_r  <= 1'b0;
      main_cap_r   <= stkundo_pkg::MAIN_CAP_RESET;
      hist_cap_r   <= stkundo_pkg::HIST_CAP_RESET;
    end else begin
      state_r      <= state_nxt;
      main_count_r <= main_count_nxt;
      hist_count_r <= hist_count_nxt;
      show_idx_r   <= show_idx_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == stkundo_pkg::CFG_MAIN_CAP) begin
          main_cap_r <= cfg_wdata[stkundo_pkg::MCAP_W-1:0];
        end else if (cfg_index == stkundo_pkg::CFG_HIST_CAP) begin
          hist_cap_r <= cfg_wdata[stkundo_pkg::HCAP_W-1:0];
        end
      end
    end
  end

  // Output payload needs no reset.
  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_depth_r  <= out_depth_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (main_we) begin
      main_mem[main_waddr] <= main_wdata;
    end
    if (main_re) begin
      main_rd_r <= main_mem[main_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    if (hist_re) begin
      hist_rd_r <= hist_mem[hist_raddr];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign out_status    = out_status_r;
  assign out_depth_now = stkundo_pkg::DEPTH_W'(out_depth_r);
  assign out_last      = out_last_r;

  // The main stack never holds more entries than the store has.
  a_main_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(main_count_r) <= stkundo_pkg::MAIN_DEPTH)
    else $error("main stack count beyond store depth");

  // The history never holds more entries than the store has.
  a_hist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(hist_count_r) <= stkundo_pkg::HISTORY_DEPTH)
    else $error("history count beyond store depth");

  // No new item is taken while one is still in work.
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("input accepted while busy");

  // A push always leaves its result in the output register in the next cycle.
  a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_operation == stkundo_pkg::OP_PUSH) |=> (out_valid_r && out_last_r))
    else $error("push produced no result");

  // Pop and undo finish with a single last result and return to idle.
  a_pop_finish: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_POP || state_r == S_UNDO) && out_free) |=>
      (state_r == S_IDLE && out_valid_r && out_last_r))
    else $error("pop or undo did not complete");

endmodule
